// ===== rtl/shfp_pkg.sv =====
`default_nettype none

package shfp_pkg;

	// Line layout
	localparam int StoreDepth     = 35;
	localparam int StoreEntries   = 2 * StoreDepth;
	localparam int StoreAw        = 7;
	localparam int PressureChars  = 70;
	localparam int SleepChars     = 34;
	localparam int CharsMax       = 127;
	localparam int PressureValues = 16;
	localparam int SleepValues    = 11;
	localparam int FullScale      = 4095;
	localparam int OutDepth       = 4;
	localparam int JobDepth       = 2;

	localparam logic [7:0] TrailerByte = 8'h55;

	// Characters that steer the parser
	localparam logic [7:0] ChOpen  = 8'h5B;
	localparam logic [7:0] ChClose = 8'h5D;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpB   = 8'h42;
	localparam logic [7:0] ChOne   = 8'h31;
	localparam logic [7:0] ChTwo   = 8'h32;
	localparam logic [7:0] ChThree = 8'h33;

	// Frame kinds
	localparam logic KindPressure = 1'b0;
	localparam logic KindSleep    = 1'b1;

	typedef struct packed {
		logic                en;
		logic [StoreAw-1:0]  addr;
		logic [7:0]          data;
	} store_wr_t;

	typedef struct packed {
		logic kind;
		logic bank;
	} job_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         idx;
		logic signed [16:0] value;
		logic               last;
	} result_t;

	// Byte positions that feed one decoded value
	typedef struct packed {
		logic [5:0] lo;
		logic [5:0] hi;
		logic       pair;
	} src_t;

	// Returns {valid, nibble}; the nibble is zero for a non-hex character.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = '0;
			if (c inside {[8'h30:8'h39]}) begin
				r = {1'b1, 4'(c - 8'h30)};
			end else if (c inside {[8'h41:8'h46]}) begin
				r = {1'b1, 4'(c - 8'h37)};
			end else if (c inside {[8'h61:8'h66]}) begin
				r = {1'b1, 4'(c - 8'h57)};
			end
			return r;
		end
	endfunction

	// Source bytes of value k; data byte i after the two header bytes sits at store entry 2 + i.
	function automatic src_t value_src(input logic kind, input logic [3:0] k);
		src_t s;
		begin
			s.lo   = {1'b0, k, 1'b0} + 6'd2;
			s.hi   = {1'b0, k, 1'b0} + 6'd3;
			s.pair = 1'b1;
			if (kind == KindSleep) begin
				s.pair = 1'b0;
				s.lo   = {2'b00, k} + 6'd2;
				s.hi   = s.lo;
				case (k)
					4'd6: begin
						s.lo = 6'd8;  s.hi = 6'd9;  s.pair = 1'b1;
					end
					4'd7: begin
						s.lo = 6'd10; s.hi = 6'd11; s.pair = 1'b1;
					end
					4'd8: begin
						s.lo = 6'd12; s.hi = 6'd12;
					end
					4'd9: begin
						s.lo = 6'd13; s.hi = 6'd14; s.pair = 1'b1;
					end
					4'd10: begin
						s.lo = 6'd15; s.hi = 6'd15;
					end
					default: begin
					end
				endcase
			end
			return s;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/shfp_front.sv =====
`default_nettype none

module shfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          char_code,
	input  logic                line_end,
	input  logic                job_full,
	output logic                full,
	output shfp_pkg::store_wr_t store_wr,
	output logic                job_push,
	output shfp_pkg::job_t      job
);
	import shfp_pkg::*;

	typedef enum logic [1:0] {PH_OPEN, PH_STAMP, PH_PAYLOAD} phase_t;

	phase_t      phase_q, phase_n;
	logic [6:0]  chars_q, chars_n;
	logic [3:0]  pend_q, pend_n;
	logic [1:0]  hdr_q, hdr_n;
	logic        bad_q, bad_n;
	logic        trail_q, trail_n;
	logic        bank_q;
	logic        accept;
	logic        is_payload;
	logic        in_store;
	logic        byte_wr;
	logic [4:0]  hex;
	logic [7:0]  byte_val;
	logic        press_ok, sleep_ok;

	// The front takes characters whenever a store bank is free.
	assign full   = job_full;
	assign accept = push & ~job_full;

	assign hex        = hex_decode(char_code);
	assign is_payload = (phase_q == PH_PAYLOAD);
	assign in_store   = (chars_q < 7'(PressureChars));
	assign byte_wr    = is_payload & in_store & chars_q[0];
	assign byte_val   = {pend_q, hex[3:0]};

	// Next line state for the character on the inputs.
	always_comb begin
		phase_n = phase_q;
		case (phase_q)
			PH_OPEN: begin
				if (char_code == ChOpen) begin
					phase_n = PH_STAMP;
				end else if (char_code == ChClose) begin
					phase_n = PH_PAYLOAD;
				end
			end
			PH_STAMP: begin
				if (char_code == ChClose) begin
					phase_n = PH_PAYLOAD;
				end
			end
			default: begin
			end
		endcase

		bad_n = bad_q | ((phase_q == PH_OPEN) & (char_code == ChClose))
			| (is_payload & ~hex[4]);

		hdr_n = hdr_q;
		if (is_payload) begin
			case (chars_q)
				7'd0: hdr_n = (char_code == ChUpA) ? 2'b11 : 2'b00;
				7'd1: hdr_n = hdr_q & {char_code == ChUpB, char_code == ChUpA};
				7'd2: hdr_n = hdr_q & {char_code == ChOne, char_code == ChTwo};
				7'd3: hdr_n = hdr_q & {char_code == ChOne, char_code == ChThree};
				default: hdr_n = hdr_q;
			endcase
		end

		chars_n = chars_q;
		if (is_payload && chars_q != 7'(CharsMax)) begin
			chars_n = chars_q + 7'd1;
		end

		pend_n = pend_q;
		if (is_payload && in_store && !chars_q[0]) begin
			pend_n = hex[3:0];
		end

		// The last byte written is the trailer of a line of exact length.
		trail_n = byte_wr ? (byte_val == TrailerByte) : trail_q;
	end

	// Layout check at line end.
	assign press_ok = (phase_n == PH_PAYLOAD) & ~bad_n & (chars_n == 7'(PressureChars))
		& hdr_n[0] & trail_n;
	assign sleep_ok = (phase_n == PH_PAYLOAD) & ~bad_n & (chars_n == 7'(SleepChars))
		& hdr_n[1] & trail_n;

	// Byte store write into the bank the front owns.
	always_comb begin
		store_wr.en   = accept & byte_wr;
		store_wr.addr = (bank_q ? StoreAw'(StoreDepth) : '0) + {1'b0, chars_q[6:1]};
		store_wr.data = byte_val;
	end

	assign job_push = accept & line_end & (press_ok | sleep_ok);
	assign job.kind = sleep_ok ? KindSleep : KindPressure;
	assign job.bank = bank_q;

	// Line state registers; a line end clears them for the next line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			chars_q <= '0;
			pend_q  <= '0;
			hdr_q   <= '0;
			bad_q   <= 1'b0;
			trail_q <= 1'b0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				phase_q <= PH_OPEN;
				chars_q <= '0;
				pend_q  <= '0;
				hdr_q   <= '0;
				bad_q   <= 1'b0;
				trail_q <= 1'b0;
				if (job_push) begin
					bank_q <= ~bank_q;
				end
			end else begin
				phase_q <= phase_n;
				chars_q <= chars_n;
				pend_q  <= pend_n;
				hdr_q   <= hdr_n;
				bad_q   <= bad_n;
				trail_q <= trail_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/shfp_job_q.sv =====
`default_nettype none

module shfp_job_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  shfp_pkg::job_t wdata,
	input  logic           rd,
	output logic           full,
	output logic           valid,
	output shfp_pkg::job_t head
);
	import shfp_pkg::*;

	job_t       slot_q [JobDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'(JobDepth));
	assign valid = (cnt_q != 2'd0);
	assign head  = slot_q[rp_q];

	// Two-entry queue of finished lines, one per store bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/shfp_back.sv =====
`default_nettype none

module shfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  shfp_pkg::store_wr_t store_wr,
	input  logic                job_valid,
	input  shfp_pkg::job_t      job,
	output logic                job_done,
	input  logic                out_full,
	output logic                out_push,
	output shfp_pkg::result_t   out_data
);
	import shfp_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_RD_LO, B_RD_HI, B_CALC} bstate_t;

	logic [7:0]         mem_q [StoreEntries];
	logic [7:0]         rdata_q;
	logic [7:0]         lo_q;
	logic [3:0]         k_q;
	bstate_t            state_q;
	src_t               src;
	logic [StoreAw-1:0] base;
	logic [StoreAw-1:0] rd_addr;
	logic [15:0]        word;
	logic               last_val;

	assign src  = value_src(job.kind, k_q);
	assign base = job.bank ? StoreAw'(StoreDepth) : '0;

	// Low byte first, then the high byte, which stays addressed while waiting.
	assign rd_addr = base + ((state_q == B_RD_LO) ? {1'b0, src.lo} : {1'b0, src.hi});

	// Byte store: two banks, one write and one read port.
	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			mem_q[store_wr.addr] <= store_wr.data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	assign word     = src.pair ? {rdata_q, lo_q} : {8'h00, lo_q};
	assign last_val = (job.kind == KindSleep) ? (k_q == 4'(SleepValues - 1))
		: (k_q == 4'(PressureValues - 1));

	// Value decode for the result on the way out.
	always_comb begin
		out_data.kind  = job.kind;
		out_data.idx   = k_q;
		out_data.last  = last_val;
		if (job.kind == KindPressure) begin
			out_data.value = 17'(FullScale) - $signed({1'b0, word});
		end else begin
			out_data.value = $signed({1'b0, word});
		end
	end

	assign out_push = (state_q == B_CALC) & ~out_full;
	assign job_done = out_push & last_val;

	// Sequencer that walks the values of one frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
			lo_q    <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					k_q <= '0;
					if (job_valid) begin
						state_q <= B_RD_LO;
					end
				end
				B_RD_LO: begin
					state_q <= B_RD_HI;
				end
				B_RD_HI: begin
					lo_q    <= rdata_q;
					state_q <= B_CALC;
				end
				B_CALC: begin
					if (!out_full) begin
						if (last_val) begin
							state_q <= B_IDLE;
							k_q     <= '0;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= B_RD_LO;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/shfp_out_fifo.sv =====
`default_nettype none

module shfp_out_fifo #(
	parameter int DEPTH = shfp_pkg::OutDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  shfp_pkg::result_t wdata,
	input  logic              rd,
	output logic              full,
	output logic              empty,
	output shfp_pkg::result_t head
);
	import shfp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t       ent_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rp_q];
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sensor_hex_frame_parser_core.sv =====
`default_nettype none
// Order: the line's last character transfer queues the frame as a job; for each value the
// sequencer reads the low byte, reads the high byte and decodes, waiting while the output
// queue is full. Throughput: one character per cycle; the front stalls only while both store
// banks hold finished frames whose values have not all entered the output queue.
// Reset: arst_n clears all line, queue and sequencer state; the byte store is not cleared.

module sensor_hex_frame_parser_core #(
	parameter int OUT_DEPTH = shfp_pkg::OutDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_code,
	input  logic               line_end,
	output logic               empty,
	input  logic               pop,
	output logic               frame_kind,
	output logic [3:0]         value_index,
	output logic signed [16:0] value,
	output logic               last
);
	import shfp_pkg::*;

	store_wr_t store_wr;
	job_t      job_in, job_head;
	logic      job_push, job_full, job_valid, job_done;
	logic      out_push, out_full;
	result_t   out_data, out_head;

	shfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_code (char_code),
		.line_end  (line_end),
		.job_full  (job_full),
		.full      (full),
		.store_wr  (store_wr),
		.job_push  (job_push),
		.job       (job_in)
	);

	shfp_job_q u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.rd     (job_done),
		.full   (job_full),
		.valid  (job_valid),
		.head   (job_head)
	);

	shfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.store_wr  (store_wr),
		.job_valid (job_valid),
		.job       (job_head),
		.job_done  (job_done),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	shfp_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (out_data),
		.rd     (pop),
		.full   (out_full),
		.empty  (empty),
		.head   (out_head)
	);

	assign frame_kind  = out_head.kind;
	assign value_index = out_head.idx;
	assign value       = out_head.value;
	assign last        = out_head.last;

	// The back never pushes a result into a full output queue.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into full output queue");

	// A finished line is only queued while a bank is free.
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full job queue");

	// The front never writes the bank the back is reading.
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(store_wr.en && job_valid) |->
		((store_wr.addr >= StoreAw'(StoreDepth)) != job_head.bank))
		else $error("store write hit the bank under readout");

	// The final value of a frame carries that frame's last index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |->
		((frame_kind == KindPressure && value_index == 4'(PressureValues - 1)) ||
		 (frame_kind == KindSleep && value_index == 4'(SleepValues - 1))))
		else $error("frame end flagged on wrong index");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

	import shfp_pkg::*;

	// Characters used to build lines beyond the ones the package names
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChFour  = 8'h34;
	localparam logic [7:0] ChFive  = 8'h35;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowF  = 8'h66;
	localparam logic [7:0] ChLowZ  = 8'h7A;
	localparam logic [7:0] ChTilde = 8'h7E;
	localparam logic [7:0] ChNine  = 8'h39;

	localparam int StimChars   = 310;
	localparam int HoldCycles  = 1200;
	localparam int IdleLimit   = 4000;
	localparam int TailCycles  = 60;
	localparam int ReportLimit = 10;

	typedef enum logic [1:0] {
		SEEK_OPEN,
		IN_STAMP,
		IN_PAYLOAD
	} line_phase_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_HEADER,
		FLAW_LOWER_HDR,
		FLAW_SWAP,
		FLAW_TRAILER,
		FLAW_BADHEX,
		FLAW_SHORT,
		FLAW_EXTRA,
		FLAW_CLOSE_FIRST,
		FLAW_NO_PAYLOAD,
		FLAW_LONG,
		FLAW_NOISE
	} line_flaw_t;

	typedef enum int {
		DATA_RANDOM,
		DATA_ZERO,
		DATA_MAX
	} data_fill_t;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} line_char_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         char_code = '0;
	logic               line_end = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic               frame_kind;
	logic [3:0]         value_index;
	logic signed [16:0] value;
	logic               last;

	sensor_hex_frame_parser_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.line_end    (line_end),
		.empty       (empty),
		.pop         (pop),
		.frame_kind  (frame_kind),
		.value_index (value_index),
		.value       (value),
		.last        (last)
	);

	// Pending characters and the decoded values they are expected to produce.
	line_char_t char_q[$];
	result_t    frame_q[$];
	int         chars_left = 0;
	int         results_due = 0;
	int         chars_sent = 0;
	int         results_seen = 0;
	int         fault_count = 0;
	int         idle_cycles = 0;

	// Line parser state mirrored by the predictor.
	line_phase_t ln_phase = SEEK_OPEN;
	int          pl_chars = 0;
	logic [7:0]  pl_bytes[StoreDepth];
	logic [3:0]  hi_nib = '0;
	logic [1:0]  hdr_match = '0;
	logic        bad_char = 1'b0;

	// Driver and monitor pacing.
	logic tx_next;
	logic tx_burst = 1'b0;
	int   tx_wait = 0;
	logic rx_next;
	logic rx_burst = 1'b0;
	int   rx_wait = 0;
	int   rx_hold = 0;
	logic rx_held = 1'b0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int hex_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
		if (c >= ChLowA && c <= ChLowF) return int'(c) - ChLowA + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
		if (nib < 4'd10) return ChZero + 8'(nib);
		return (lower ? ChLowA : ChUpA) + 8'(nib - 4'd10);
	endfunction

	// Any character except the two brackets.
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == ChOpen || c == ChClose) c = ChTilde;
		return c;
	endfunction

	task automatic add_value(input logic kind, input int k, input int val, input logic fin);
		result_t r;
		r.kind = kind;
		r.idx = 4'(k);
		r.value = val[16:0];
		r.last = fin;
		frame_q.insert(frame_q.size(), r);
		results_due++;
	endtask

	// Predicts the frame values that one accepted character causes.
	task automatic parse_char(input logic [7:0] c, input logic fin);
		int h;
		int pos;
		int v;
		logic [3:0] nib;
		case (ln_phase)
			SEEK_OPEN: begin
				if (c == ChOpen) begin
					ln_phase = IN_STAMP;
				end else if (c == ChClose) begin
					// A closing bracket with no opening one spoils the line.
					ln_phase = IN_PAYLOAD;
					bad_char = 1'b1;
				end
			end
			IN_STAMP: begin
				if (c == ChClose) ln_phase = IN_PAYLOAD;
			end
			default: begin
				pos = pl_chars;
				h = hex_val(c);
				nib = '0;
				if (h < 0) bad_char = 1'b1;
				else nib = 4'(h);
				// The header must match exactly, upper case only.
				case (pos)
					0: hdr_match = (c == ChUpA) ? 2'b11 : 2'b00;
					1: hdr_match &= {c == ChUpB, c == ChUpA};
					2: hdr_match &= {c == ChOne, c == ChTwo};
					3: hdr_match &= {c == ChOne, c == ChThree};
					default: begin
					end
				endcase
				if (pos < PressureChars) begin
					if (pos % 2 == 0) hi_nib = nib;
					else pl_bytes[pos / 2] = {hi_nib, nib};
				end
				if (pl_chars < CharsMax) pl_chars++;
			end
		endcase

		if (fin) begin
			if (ln_phase == IN_PAYLOAD && !bad_char) begin
				if (pl_chars == PressureChars && hdr_match[0] &&
						pl_bytes[34] == TrailerByte) begin
					// Little-endian words taken away from full scale.
					for (int k = 0; k < PressureValues; k++) begin
						v = FullScale - int'({pl_bytes[3 + 2 * k], pl_bytes[2 + 2 * k]});
						add_value(KindPressure, k, v, k == PressureValues - 1);
					end
				end else if (pl_chars == SleepChars && hdr_match[1] &&
						pl_bytes[16] == TrailerByte) begin
					// Single bytes and little-endian pairs in file order.
					for (int k = 0; k < SleepValues; k++) begin
						case (k)
							6: v = int'({pl_bytes[9], pl_bytes[8]});
							7: v = int'({pl_bytes[11], pl_bytes[10]});
							8: v = int'(pl_bytes[12]);
							9: v = int'({pl_bytes[14], pl_bytes[13]});
							10: v = int'(pl_bytes[15]);
							default: v = int'(pl_bytes[2 + k]);
						endcase
						add_value(KindSleep, k, v, k == SleepValues - 1);
					end
				end
			end
			ln_phase = SEEK_OPEN;
			pl_chars = 0;
			hi_nib = '0;
			hdr_match = '0;
			bad_char = 1'b0;
		end
	endtask

	task automatic queue_char(input logic [7:0] c, input logic fin);
		line_char_t item;
		item.code = c;
		item.fin = fin;
		char_q.insert(char_q.size(), item);
	endtask

	// Builds one line of the given layout, optionally broken in one way.
	task automatic build_line(input logic kind, input line_flaw_t flaw, input data_fill_t fill);
		logic [7:0] pl[$];
		logic [7:0] ln[$];
		logic [7:0] c;
		logic       hdr_kind;
		int         n_data;
		int         pos;
		hdr_kind = (flaw == FLAW_SWAP) ? ~kind : kind;
		n_data = (kind == KindPressure) ? 64 : 28;
		if (flaw == FLAW_LONG) n_data = 124;
		if (hdr_kind == KindPressure) pl = '{ChUpA, ChUpA, ChTwo, ChThree};
		else pl = '{ChUpA, ChUpB, ChOne, ChOne};
		for (int i = 0; i < n_data; i++) begin
			case (fill)
				DATA_ZERO: c = ChZero;
				DATA_MAX: c = hex_char(4'hF, 1'($urandom_range(0, 1)));
				default: c = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			endcase
			pl.insert(pl.size(), c);
		end
		pl.insert(pl.size(), ChFive);
		pl.insert(pl.size(), ChFive);

		// Damage the payload.
		case (flaw)
			FLAW_HEADER: begin
				pos = $urandom_range(0, 3);
				if (pos < 2) pl[pos] = (pl[pos] == ChUpA) ? ChUpB : ChUpA;
				else pl[pos] = pl[pos] ^ 8'h01;
			end
			FLAW_LOWER_HDR: begin
				pos = $urandom_range(0, 1);
				pl[pos] = pl[pos] | 8'h20;
			end
			FLAW_TRAILER: begin
				pl[pl.size() - 1 - $urandom_range(0, 1)] = ChFour;
			end
			FLAW_BADHEX: begin
				c = 8'($urandom_range(0, 255));
				while (hex_val(c) >= 0) c = 8'($urandom_range(0, 255));
				pl[$urandom_range(0, pl.size() - 1)] = c;
			end
			FLAW_SHORT: begin
				pl.delete($urandom_range(4, pl.size() - 3));
			end
			FLAW_EXTRA: begin
				pl.insert($urandom_range(4, pl.size() - 2),
					hex_char(4'($urandom_range(0, 15)), 1'b0));
			end
			default: begin
			end
		endcase

		// Assemble prefix, timestamp and payload.
		if (flaw == FLAW_NOISE) begin
			repeat ($urandom_range(1, 8)) ln.insert(ln.size(), 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) ln.insert(ln.size(), plain_char());
			if (flaw != FLAW_CLOSE_FIRST) begin
				ln.insert(ln.size(), ChOpen);
				repeat ($urandom_range(0, 3)) begin
					c = 8'($urandom_range(0, 255));
					ln.insert(ln.size(), (c == ChClose) ? ChNine : c);
				end
			end
			if (flaw != FLAW_NO_PAYLOAD) begin
				ln.insert(ln.size(), ChClose);
				foreach (pl[i]) ln.insert(ln.size(), pl[i]);
			end
		end
		foreach (ln[i]) queue_char(ln[i], i == ln.size() - 1);
	endtask

	// Sender: offers the pending characters with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			tx_next = push;
			if (push && !full) begin
				parse_char(char_q[0].code, char_q[0].fin);
				char_q.pop_front();
				chars_left--;
				chars_sent++;
				if (chars_sent % 48 == 0) tx_burst = ~tx_burst;
				tx_wait = tx_burst ? 0 : $urandom_range(0, 4);
				tx_next = 1'b0;
			end
			if (!tx_next && char_q.size() != 0) begin
				if (tx_wait > 0) begin
					tx_wait--;
				end else begin
					tx_next = 1'b1;
					char_code <= char_q[0].code;
					line_end <= char_q[0].fin;
				end
			end
			push <= tx_next;
		end
	end

	// Compares one transfer on the result side with the oldest expectation.
	task automatic check_result();
		result_t want;
		results_seen++;
		if (frame_q.size() == 0) begin
			fault_count++;
			if (fault_count <= ReportLimit) begin
				$display("unexpected value: kind %0d idx %0d value %0d last %0d",
					frame_kind, value_index, value, last);
			end
		end else begin
			want = frame_q.pop_front();
			results_due--;
			if (frame_kind !== want.kind || value_index !== want.idx ||
					value !== want.value || last !== want.last) begin
				fault_count++;
				if (fault_count <= ReportLimit) begin
					$display("value %0d: expected kind %0d idx %0d value %0d last %0d",
						results_seen, want.kind, want.idx, $signed(want.value), want.last);
					$display("value %0d: got      kind %0d idx %0d value %0d last %0d",
						results_seen, frame_kind, value_index, value, last);
				end
			end
		end
	endtask

	// Receiver: pops with random gaps, and once holds off long enough to fill the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			rx_next = pop;
			if (pop && !empty) begin
				check_result();
				if (results_seen % 20 == 0) rx_burst = ~rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 4);
				if (!rx_held) begin
					rx_hold = HoldCycles;
					rx_held = 1'b1;
				end
				rx_next = 1'b0;
			end
			if (!rx_next) begin
				if (rx_hold > 0) rx_hold--;
				else if (rx_wait > 0) rx_wait--;
				else rx_next = 1'b1;
			end
			pop <= rx_next;
		end
	end

	// Watchdog on cycles without any transfer while work is outstanding.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else if (chars_left != 0 || results_due != 0) idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("sensor_hex_frame_parser_core: mismatch");
				$finish;
			end
		end
	end

	initial begin
		line_flaw_t next_flaw;
		line_flaw_t flaw;
		data_fill_t fill;
		logic       kind;
		int         r;

		foreach (pl_bytes[i]) pl_bytes[i] = '0;

		// Short special lines: lone closing bracket, end before payload,
		// empty payload, non-hex after extreme codes, lower-case data,
		// and an opening bracket that falls inside the payload.
		queue_char(ChClose, 1'b1);
		queue_char(ChOpen, 1'b1);
		queue_char(ChOpen, 1'b0);
		queue_char(ChClose, 1'b1);
		queue_char(8'hFF, 1'b0);
		queue_char(8'h00, 1'b0);
		queue_char(ChOpen, 1'b0);
		queue_char(8'h80, 1'b0);
		queue_char(8'h7F, 1'b0);
		queue_char(ChClose, 1'b0);
		queue_char(ChUpA, 1'b0);
		queue_char(ChLowZ, 1'b1);
		queue_char(ChOpen, 1'b0);
		queue_char(ChClose, 1'b0);
		queue_char(ChLowF, 1'b0);
		queue_char(ChZero, 1'b1);
		queue_char(ChClose, 1'b0);
		queue_char(ChOpen, 1'b0);
		queue_char(ChUpA, 1'b1);

		// Pressure frames at both ends of the range; they also back up the
		// block while the receiver holds off.
		build_line(KindPressure, FLAW_NONE, DATA_ZERO);
		build_line(KindPressure, FLAW_NONE, DATA_MAX);

		// Mostly well-formed lines; the damaged ones step through the kinds of damage.
		next_flaw = FLAW_HEADER;
		while (char_q.size() < StimChars) begin
			if ($urandom_range(0, 9) < 6) begin
				r = $urandom_range(0, 9);
				fill = (r == 0) ? DATA_ZERO : (r == 1) ? DATA_MAX : DATA_RANDOM;
				kind = 1'($urandom_range(0, 1));
				build_line(kind, FLAW_NONE, fill);
			end else begin
				if (next_flaw != FLAW_NONE) begin
					flaw = next_flaw;
					next_flaw = (next_flaw == FLAW_NOISE) ? FLAW_NONE :
						line_flaw_t'(int'(next_flaw) + 1);
				end else begin
					flaw = line_flaw_t'($urandom_range(FLAW_HEADER, FLAW_NOISE));
				end
				kind = ($urandom_range(0, 3) == 0) ? KindPressure : KindSleep;
				build_line(kind, flaw, DATA_RANDOM);
			end
		end
		chars_left = char_q.size();

		wait (arst_n);
		wait (chars_left == 0);
		wait (results_due == 0);
		repeat (TailCycles) @(posedge clk);
		if (fault_count == 0 && results_due == 0) begin
			$display("sensor_hex_frame_parser_core: match");
		end else begin
			$display("sensor_hex_frame_parser_core: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
